// ----- rtl/esfla_pkg.sv -----
// Shared types and constants for the element slot free-list allocator.
// No dependencies; every other file of the block but esfla_ram imports this package.
package esfla_pkg;

  localparam int SLOTS     = 1024;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CAP_W     = SLOT_W + 1;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = CAP_W;

  localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_USED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 1'b1;

  localparam logic [SLOT_W-1:0] CFG_USED_RST = '0;
  localparam logic [CAP_W-1:0]  CFG_CAP_RST  = CAP_W'(SLOTS);

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_ALLOC,
    S_FREE,
    S_WALK_RD,
    S_WALK_CHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                clr_step;
    logic                init_step;
    logic                init_fin;
    logic                ld_req;
    logic                rd_link;
    logic                rd_use_in;
    logic                alloc_commit;
    logic                free_commit;
    logic                walk_start;
    logic                walk_rd;
    logic                walk_dec;
    logic                emit;
    logic                emit_alloc;
    logic [STATUS_W-1:0] status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic head_zero;
    logic use_rdata;
    logic idx_is_top;
    logic top_zero;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/esfla_in_if.sv -----
// Request channel of the slot allocator: valid/ready plus func and slot index.
// Depends on esfla_pkg.
interface esfla_in_if;
  import esfla_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  slot_t             slot_index;

  modport source (output valid, func, slot_index, input ready);
  modport sink   (input valid, func, slot_index, output ready);
endinterface

// ----- rtl/esfla_out_if.sv -----
// Result channel of the slot allocator: valid/ready plus slot, status, high water.
// Depends on esfla_pkg.
interface esfla_out_if;
  import esfla_pkg::*;

  logic                valid;
  logic                ready;
  slot_t               slot;
  logic [STATUS_W-1:0] status;
  slot_t               high_water;

  modport source (output valid, slot, status, high_water, input ready);
  modport sink   (input valid, slot, status, high_water, output ready);
endinterface

// ----- rtl/element_slot_free_list_allocator_unit.sv -----
// Top level of the element slot free-list allocator: controller plus datapath.
// Depends on esfla_pkg, esfla_in_if, esfla_out_if, esfla_ctrl, esfla_dpath.
//
//   port     dir   handshake     payload
//   in_ch    in    valid/ready   func, slot_index
//   out_ch   out   valid/ready   slot, status, high_water
//   cfg_*    in    cfg_we        cfg_index, cfg_wdata
//
// Allocate, free and unused func codes: IDLE takes the request, then ALLOC, FREE or RESP emits the result.
// Free of the high-water slot: FREE, then WALK_RD and WALK_CHK per slot the mark steps down, then RESP.
// Init: one sweep over the link and in-use RAMs, then RESP.
// After reset a clearing pass over all SLOTS entries zeroes the in-use RAM; in_ch.ready stays low.
// One request at a time; a stalled result holds the next request in its final state.
module element_slot_free_list_allocator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  esfla_in_if.sink                         in_ch,
  esfla_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [esfla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esfla_pkg::CFG_W-1:0]      cfg_wdata
);
  import esfla_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;

  esfla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  esfla_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_slot_index  (in_ch.slot_index),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_slot       (out_ch.slot),
    .out_status     (out_ch.status),
    .out_high_water (out_ch.high_water)
  );

  assign in_ch.ready = in_ready;

  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result emitted over a pending result");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.init_step, cmd.alloc_commit, cmd.free_commit}))
    else $error("conflicting RAM write commands");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in flight");

  a_alloc_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_alloc) |-> !sts.head_zero)
    else $error("null slot handed out");

endmodule

// ----- rtl/esfla_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module esfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/esfla_ctrl.sv -----
// Controller FSM of the slot allocator: sequences clear, init, alloc, free, walk.
// Depends on esfla_pkg; drives commands into esfla_dpath.
module esfla_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [esfla_pkg::FUNC_W-1:0]     in_func,
  output logic                             in_ready,
  input  esfla_pkg::dp_sts_t               sts,
  output esfla_pkg::ctrl_cmd_t             cmd
);
  import esfla_pkg::*;

  state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    cmd      = '0;
    st_nxt   = st_r;
    in_ready = 1'b0;
    case (st_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_last) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          case (in_func)
            FUNC_INIT: begin
              st_nxt = S_INIT;
            end
            FUNC_ALLOC: begin
              cmd.rd_link = 1'b1;
              st_nxt      = S_ALLOC;
            end
            FUNC_FREE: begin
              cmd.rd_use_in = 1'b1;
              st_nxt        = S_FREE;
            end
            default: begin
              st_nxt = S_RESP;
            end
          endcase
        end
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.init_fin = 1'b1;
          st_nxt       = S_RESP;
        end
      end
      S_ALLOC: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.head_zero) begin
            cmd.status = STATUS_FULL;
          end else begin
            cmd.status       = STATUS_OK;
            cmd.alloc_commit = 1'b1;
            cmd.emit_alloc   = 1'b1;
          end
          st_nxt = S_IDLE;
        end
      end
      S_FREE: begin
        if (!sts.use_rdata) begin
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            cmd.status = STATUS_NOT_USED;
            st_nxt     = S_IDLE;
          end
        end else if (sts.idx_is_top) begin
          cmd.free_commit = 1'b1;
          cmd.walk_start  = 1'b1;
          st_nxt          = S_WALK_RD;
        end else if (sts.out_free) begin
          cmd.free_commit = 1'b1;
          cmd.emit        = 1'b1;
          cmd.status      = STATUS_OK;
          st_nxt          = S_IDLE;
        end
      end
      S_WALK_RD: begin
        if (sts.top_zero) begin
          st_nxt = S_RESP;
        end else begin
          cmd.walk_rd = 1'b1;
          st_nxt      = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (sts.use_rdata) begin
          st_nxt = S_RESP;
        end else begin
          cmd.walk_dec = 1'b1;
          st_nxt       = S_WALK_RD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.status = STATUS_OK;
          st_nxt     = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/esfla_dpath.sv -----
// Datapath of the slot allocator: config regs, head/high-water regs, link and
// in-use RAMs, sweep counter and result register. Depends on esfla_pkg, esfla_ram.
module esfla_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  esfla_pkg::ctrl_cmd_t               cmd,
  output esfla_pkg::dp_sts_t                 sts,
  input  esfla_pkg::slot_t                   in_slot_index,
  input  logic                               cfg_we,
  input  logic [esfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [esfla_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_ready,
  output esfla_pkg::slot_t                   out_slot,
  output logic [esfla_pkg::STATUS_W-1:0]     out_status,
  output esfla_pkg::slot_t                   out_high_water
);
  import esfla_pkg::*;

  slot_t               cfg_used_r;
  logic [CAP_W-1:0]    cfg_cap_r;
  slot_t               head_r, head_nxt;
  slot_t               top_r, top_nxt;
  slot_t               k_r, k_nxt;
  slot_t               idx_r;
  logic                out_valid_r, out_valid_nxt;
  slot_t               out_slot_r;
  logic [STATUS_W-1:0] out_status_r;
  slot_t               out_hw_r;

  logic [CAP_W-1:0]    cap_eff;
  logic [CAP_W-1:0]    used_ext;
  logic [CAP_W-1:0]    used_eff;
  logic [CAP_W-1:0]    k_ext;
  logic [CAP_W-1:0]    used_inc;
  logic                init_use;
  slot_t               init_link;
  slot_t               init_head;

  logic                use_we, use_re, use_wdata, use_rdata;
  slot_t               use_waddr, use_raddr;
  logic                link_we;
  slot_t               link_wdata, link_rdata;
  slot_t               wr_addr;

  // effective init parameters
  always_comb begin
    if (cfg_cap_r < CAP_W'(2)) begin
      cap_eff = CAP_W'(2);
    end else if (cfg_cap_r > CAP_W'(SLOTS)) begin
      cap_eff = CAP_W'(SLOTS);
    end else begin
      cap_eff = cfg_cap_r;
    end
    used_ext = {1'b0, cfg_used_r};
    if (used_ext > cap_eff - CAP_W'(1)) begin
      used_eff = cap_eff - CAP_W'(1);
    end else begin
      used_eff = used_ext;
    end
    k_ext     = {1'b0, k_r};
    used_inc  = used_eff + CAP_W'(1);
    init_use  = (k_r != '0) && (k_ext <= used_eff);
    init_link = ((k_ext > used_eff) && (k_ext + CAP_W'(1) < cap_eff)) ?
                SLOT_W'(k_ext + CAP_W'(1)) : '0;
    init_head = (used_inc < cap_eff) ? used_inc[SLOT_W-1:0] : '0;
  end

  // RAM port muxes
  always_comb begin
    if (cmd.alloc_commit) begin
      wr_addr = head_r;
    end else if (cmd.free_commit) begin
      wr_addr = idx_r;
    end else begin
      wr_addr = k_r;
    end
    use_we     = cmd.clr_step | cmd.init_step | cmd.alloc_commit | cmd.free_commit;
    use_waddr  = wr_addr;
    use_wdata  = cmd.init_step ? init_use : cmd.alloc_commit;
    use_re     = cmd.rd_use_in | cmd.walk_rd;
    use_raddr  = cmd.walk_rd ? top_r : in_slot_index;
    link_we    = cmd.init_step | cmd.alloc_commit | cmd.free_commit;
    if (cmd.init_step) begin
      link_wdata = init_link;
    end else if (cmd.free_commit) begin
      link_wdata = head_r;
    end else begin
      link_wdata = '0;
    end
  end

  esfla_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_use_ram (
    .clk   (clk),
    .we    (use_we),
    .waddr (use_waddr),
    .wdata (use_wdata),
    .re    (use_re),
    .raddr (use_raddr),
    .rdata (use_rdata)
  );

  esfla_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (wr_addr),
    .wdata (link_wdata),
    .re    (cmd.rd_link),
    .raddr (head_r),
    .rdata (link_rdata)
  );

  always_comb begin
    head_nxt = head_r;
    if (cmd.init_fin) begin
      head_nxt = init_head;
    end else if (cmd.alloc_commit) begin
      head_nxt = link_rdata;
    end else if (cmd.free_commit) begin
      head_nxt = idx_r;
    end

    top_nxt = top_r;
    if (cmd.init_fin) begin
      top_nxt = used_eff[SLOT_W-1:0];
    end else if (cmd.alloc_commit) begin
      top_nxt = (head_r > top_r) ? head_r : top_r;
    end else if (cmd.walk_start || cmd.walk_dec) begin
      top_nxt = top_r - SLOT_W'(1);
    end

    k_nxt = k_r;
    if (cmd.clr_step || cmd.init_step) begin
      k_nxt = sts.sweep_last ? '0 : k_r + SLOT_W'(1);
    end

    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_used_r  <= CFG_USED_RST;
      cfg_cap_r   <= CFG_CAP_RST;
      head_r      <= '0;
      top_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INITIAL_USED: cfg_used_r <= cfg_wdata[SLOT_W-1:0];
          REG_CAPACITY:     cfg_cap_r  <= cfg_wdata;
          default:          cfg_cap_r  <= cfg_cap_r;
        endcase
      end
      head_r      <= head_nxt;
      top_r       <= top_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      idx_r <= in_slot_index;
    end
    if (cmd.emit) begin
      out_slot_r   <= cmd.emit_alloc ? head_r : '0;
      out_status_r <= cmd.status;
      out_hw_r     <= top_nxt;
    end
  end

  assign sts.sweep_last = (k_r == SLOT_W'(SLOTS - 1));
  assign sts.head_zero  = (head_r == '0);
  assign sts.use_rdata  = use_rdata;
  assign sts.idx_is_top = (idx_r == top_r);
  assign sts.top_zero   = (top_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_slot       = out_slot_r;
  assign out_status     = out_status_r;
  assign out_high_water = out_hw_r;

endmodule
